>>> rtl/gdo_pkg.sv
`timescale 1ns / 1ps
// gdo_pkg: op and status codes, month length and leap year helpers
// for the gregorian date offset block; no dependencies

package gdo_pkg;

    typedef enum logic [2:0] {
        OP_ADD_DAYS   = 3'd0,
        OP_SUB_DAYS   = 3'd1,
        OP_ADD_MONTHS = 3'd2,
        OP_SUB_MONTHS = 3'd3,
        OP_ADD_YEARS  = 3'd4,
        OP_SUB_YEARS  = 3'd5,
        OP_NOP6       = 3'd6,
        OP_NOP7       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] DAYS_31   = 5'd31;

    // multiplicative inverse of 25 modulo 2^16, and the largest quotient
    // for which a 16-bit value is a multiple of 25
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    // reciprocal of 3 scaled by 2^19, exact for 18-bit operands
    localparam logic [17:0] RECIP3    = 18'd174763;

    // 4/100/400 rule; divisibility by 25 via the modular inverse
    function automatic logic is_leap(input logic [15:0] y);
        logic [15:0] prod;
        logic        div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_MAX);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    // days in month m; invalid months read as 31
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                   len = DAYS_31;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/gregorian_date_offset_top.sv
`timescale 1ns / 1ps
// gregorian_date_offset_top: moves a Gregorian date by days, months or years
// depends on gdo_pkg (op/status codes, month length, leap year test)
//
// Usage:
//   Drive op, day_in, month_in, year_in and amount with start high while busy
//   is low; the item is taken at that clock edge and busy rises. One result
//   item follows on day_out, month_out, year_out and status, marked by done
//   for exactly one cycle; the receiver must take it then, it cannot stall.
//   busy falls in the cycle that done is high, so a new item may be started
//   in that same cycle.
// Sequence of states (start edge to done edge):
//   invalid date or unused op: check, then done
//   year ops: check, clamp, done; month ops: check, month add, quotient, fix,
//   clamp, done; day ops: check, then the day loop, one step per month boundary
//   crossed plus a final step, then done. Any op goes to done early when the
//   result leaves range. The day loop runs one month per cycle through one leap
//   year unit and the month length logic for the current and previous month.
// Reset: rst_n clears the sequencer and the done strobe; the block comes up
//   idle with busy low. The result ports hold no meaning until the first done.

module gregorian_date_offset_top #(
    parameter int unsigned YEAR_MAX   = 65535,
    parameter int unsigned AMOUNT_MAX = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [15:0] year_in,
    input  logic [15:0] amount,
    output logic        done,
    output logic [4:0]  day_out,
    output logic [3:0]  month_out,
    output logic [15:0] year_out,
    output logic [1:0]  status
);

    localparam logic [15:0] YEAR_CAP = 16'(YEAR_MAX);
    localparam logic [15:0] AMT_CAP  = 16'(AMOUNT_MAX);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_DADD  = 9'b000000100,
        S_DSUB  = 9'b000001000,
        S_MADD  = 9'b000010000,
        S_MQUO  = 9'b000100000,
        S_MFIX  = 9'b001000000,
        S_CLAMP = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    gdo_pkg::op_t      op_reg, op_next;
    gdo_pkg::status_t  stat_reg, stat_next;
    logic [4:0]        din_reg, din_next;
    logic [3:0]        min_reg, min_next;
    logic [15:0]       yin_reg, yin_next;
    logic [4:0]        d_reg, d_next;
    logic [3:0]        m_reg, m_next;
    logic [15:0]       y_reg, y_next;
    logic [15:0]       rem_reg, rem_next;
    logic [19:0]       t_reg, t_next;
    logic [16:0]       q_reg, q_next;
    logic              done_reg, done_next;
    logic [4:0]        dout_reg, dout_next;
    logic [3:0]        mout_reg, mout_next;
    logic [15:0]       yout_reg, yout_next;
    logic [1:0]        sout_reg, sout_next;

    // month length (current and previous month) and leap year logic, fed from the working date
    logic              cur_leap;
    logic [4:0]        lim;
    logic [4:0]        prev_len;
    logic              date_ok;
    logic [16:0]       day_sum;
    logic [16:0]       year_sum;
    logic [35:0]       quo_prod;
    logic [20:0]       q_times12;
    logic [3:0]        month_rem;

    assign cur_leap = gdo_pkg::is_leap(y_reg);
    assign lim      = gdo_pkg::month_len(m_reg, cur_leap);
    assign prev_len = (m_reg == gdo_pkg::MONTH_JAN) ? gdo_pkg::DAYS_31
                    : gdo_pkg::month_len(m_reg - 4'd1, cur_leap);

    assign date_ok  = (m_reg >= gdo_pkg::MONTH_JAN) && (m_reg <= gdo_pkg::MONTH_DEC)
                   && (y_reg != 16'd0) && (y_reg <= YEAR_CAP)
                   && (d_reg != 5'd0) && (d_reg <= lim);

    assign day_sum   = {12'd0, d_reg} + {1'b0, rem_reg};
    assign year_sum  = {1'b0, y_reg} + {1'b0, rem_reg};
    assign quo_prod  = {18'd0, t_reg[19:2]} * {18'd0, gdo_pkg::RECIP3};
    assign q_times12 = {1'b0, q_reg, 3'b000} + {2'b00, q_reg, 2'b00};
    assign month_rem = 4'(({1'b0, t_reg}) - q_times12);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        stat_next  = stat_reg;
        din_next   = din_reg;
        min_next   = min_reg;
        yin_next   = yin_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        rem_next   = rem_reg;
        t_next     = t_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        dout_next  = dout_reg;
        mout_next  = mout_reg;
        yout_next  = yout_reg;
        sout_next  = sout_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = gdo_pkg::op_t'(op);
                    din_next   = day_in;
                    min_next   = month_in;
                    yin_next   = year_in;
                    d_next     = day_in;
                    m_next     = month_in;
                    y_next     = year_in;
                    rem_next   = (amount > AMT_CAP) ? AMT_CAP : amount;
                    stat_next  = gdo_pkg::STAT_OK;
                    state_next = S_CHECK;
                end
            end

            // validate the date and dispatch on the op
            S_CHECK:
            begin
                if (!date_ok)
                begin
                    stat_next  = gdo_pkg::STAT_INVALID;
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (op_reg)
                        gdo_pkg::OP_ADD_DAYS: state_next = S_DADD;
                        gdo_pkg::OP_SUB_DAYS: state_next = S_DSUB;
                        gdo_pkg::OP_ADD_MONTHS, gdo_pkg::OP_SUB_MONTHS:
                        begin
                            t_next = {1'b0, y_reg, 3'b000} + {2'b00, y_reg, 2'b00}
                                   + {16'd0, m_reg - 4'd1};
                            state_next = S_MADD;
                        end
                        gdo_pkg::OP_ADD_YEARS:
                        begin
                            if (year_sum > {1'b0, YEAR_CAP})
                            begin
                                stat_next  = gdo_pkg::STAT_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                y_next     = year_sum[15:0];
                                state_next = S_CLAMP;
                            end
                        end
                        gdo_pkg::OP_SUB_YEARS:
                        begin
                            if (rem_reg >= y_reg)
                            begin
                                stat_next  = gdo_pkg::STAT_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                y_next     = y_reg - rem_reg;
                                state_next = S_CLAMP;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            // forward one month per cycle until the rest fits
            S_DADD:
            begin
                if (day_sum > {12'd0, lim})
                begin
                    rem_next = rem_reg - ({11'd0, lim} - {11'd0, d_reg});
                    d_next   = 5'd0;
                    if (m_reg == gdo_pkg::MONTH_DEC)
                    begin
                        if (y_reg == YEAR_CAP)
                        begin
                            stat_next  = gdo_pkg::STAT_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            m_next = gdo_pkg::MONTH_JAN;
                            y_next = y_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        m_next = m_reg + 4'd1;
                    end
                end
                else
                begin
                    d_next     = day_sum[4:0];
                    state_next = S_DONE;
                end
            end

            // back one month per cycle, landing on the previous month's end
            S_DSUB:
            begin
                if (rem_reg >= {11'd0, d_reg})
                begin
                    rem_next = rem_reg - {11'd0, d_reg};
                    if (m_reg == gdo_pkg::MONTH_JAN)
                    begin
                        if (y_reg <= 16'd1)
                        begin
                            stat_next  = gdo_pkg::STAT_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            m_next = gdo_pkg::MONTH_DEC;
                            y_next = y_reg - 16'd1;
                            d_next = prev_len;
                        end
                    end
                    else
                    begin
                        m_next = m_reg - 4'd1;
                        d_next = prev_len;
                    end
                end
                else
                begin
                    d_next     = d_reg - rem_reg[4:0];
                    state_next = S_DONE;
                end
            end

            // move the month count
            S_MADD:
            begin
                if (op_reg == gdo_pkg::OP_ADD_MONTHS)
                begin
                    t_next     = t_reg + {4'd0, rem_reg};
                    state_next = S_MQUO;
                end
                else if (({4'd0, rem_reg} + 20'd12) > t_reg)
                begin
                    stat_next  = gdo_pkg::STAT_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    t_next     = t_reg - {4'd0, rem_reg};
                    state_next = S_MQUO;
                end
            end

            // year = month count / 12 by reciprocal of 3 after a shift
            S_MQUO:
            begin
                q_next     = quo_prod[35:19];
                state_next = S_MFIX;
            end

            // remainder gives the month; range check on the year
            S_MFIX:
            begin
                if ((q_reg == 17'd0) || (q_reg > {1'b0, YEAR_CAP}))
                begin
                    stat_next  = gdo_pkg::STAT_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    y_next     = q_reg[15:0];
                    m_next     = month_rem + 4'd1;
                    state_next = S_CLAMP;
                end
            end

            // clamp day to the target month's length
            S_CLAMP:
            begin
                if (d_reg > lim)
                begin
                    d_next = lim;
                end
                state_next = S_DONE;
            end

            // present the result item
            S_DONE:
            begin
                done_next = 1'b1;
                sout_next = stat_reg;
                if (stat_reg == gdo_pkg::STAT_OK)
                begin
                    dout_next = d_reg;
                    mout_next = m_reg;
                    yout_next = y_reg;
                end
                else
                begin
                    dout_next = din_reg;
                    mout_next = min_reg;
                    yout_next = yin_reg;
                end
                state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        stat_reg <= stat_next;
        din_reg  <= din_next;
        min_reg  <= min_next;
        yin_reg  <= yin_next;
        d_reg    <= d_next;
        m_reg    <= m_next;
        y_reg    <= y_next;
        rem_reg  <= rem_next;
        t_reg    <= t_next;
        q_reg    <= q_next;
        dout_reg <= dout_next;
        mout_reg <= mout_next;
        yout_reg <= yout_next;
        sout_reg <= sout_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign day_out   = dout_reg;
    assign month_out = mout_reg;
    assign year_out  = yout_reg;
    assign status    = sout_reg;

endmodule
